[src/ccmd_pkg.sv]
// Shared types and constants for the fewest-coins solver.
package ccmd_pkg;

  localparam int OPC_W  = 2;
  localparam int COIN_W = 16;
  localparam int AMT_W  = 14;
  // Table entries hold counts up to target plus one
  localparam int CNT_W  = 15;

  localparam logic [OPC_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OPC_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OPC_W-1:0] OP_SOLVE  = 2'd2;

  typedef struct packed {
    logic [OPC_W-1:0]  opcode;
    logic [COIN_W-1:0] coin_value;
    logic [AMT_W-1:0]  target_amount;
  } req_t;

  typedef struct packed {
    logic [AMT_W-1:0] fewest_coins;
    logic             reachable;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;
    logic append;
    logic start;
    logic init;
    logic scan;
    logic write;
    logic load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic trivial;
    logic last_coin;
    logic last_amt;
    logic out_free;
  } sts_t;

endpackage

[src/coin_change_min_coins_dp.sv]
// Top level of the fewest-coins solver: controller plus datapath.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------
//  req     | in        | req_valid / req_ready | opcode, coin_value, target
//  rsp     | out       | rsp_valid / rsp_ready | fewest_coins, reachable
//
// Clear and append items are taken in the idle state and give no result.
// During a solve, each amount reads every coin and then one finished table
// entry per coin through the single read port of the amount table, followed
// by a drain state and a write state.
// Reset clears the coin count and control state; neither memory is cleared.
// A finished result waits in the output register; a solve that completes
// while the previous result is still untaken holds until it is taken.
module coin_change_min_coins_dp #(
  parameter int MAX_COINS  = 12,
  parameter int MAX_AMOUNT = 16384
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  ccmd_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output ccmd_pkg::rsp_t  rsp
);
  import ccmd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ccmd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .opcode    (req.opcode),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ccmd_dp #(
    .MAX_COINS  (MAX_COINS),
    .MAX_AMOUNT (MAX_AMOUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

[src/ccmd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ccmd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/ccmd_ctrl.sv]
// Sequencing state machine for the fewest-coins solver.
module ccmd_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  logic [ccmd_pkg::OPC_W-1:0]    opcode,
  output logic                          req_ready,
  input  ccmd_pkg::sts_t                sts,
  output ccmd_pkg::cmd_t                cmd
);
  import ccmd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          case (opcode)
            OP_CLEAR:  cmd.clear = 1'b1;
            OP_APPEND: cmd.append = 1'b1;
            OP_SOLVE: begin
              cmd.start  = 1'b1;
              state_next = S_INIT;
            end
            default: ;
          endcase
        end
      end
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = sts.trivial ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.last_coin) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.write  = 1'b1;
        state_next = sts.last_amt ? S_DONE : S_SCAN;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[src/ccmd_dp.sv]
// Datapath: coin list, amount table, candidate pipeline and result register.
module ccmd_dp #(
  parameter int MAX_COINS  = 12,
  parameter int MAX_AMOUNT = 16384
) (
  input  logic            clk,
  input  logic            rst,
  input  ccmd_pkg::req_t  req,
  input  ccmd_pkg::cmd_t  cmd,
  output ccmd_pkg::sts_t  sts,
  input  logic            rsp_ready,
  output logic            rsp_valid,
  output ccmd_pkg::rsp_t  rsp
);
  import ccmd_pkg::*;

  localparam int CIW = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
  localparam int CCW = $clog2(MAX_COINS + 1);
  localparam int TAW = (MAX_AMOUNT > 1) ? $clog2(MAX_AMOUNT) : 1;

  logic [CCW-1:0]    coin_count;
  logic [CIW-1:0]    k;
  logic [AMT_W-1:0]  target;
  logic [AMT_W-1:0]  amt;
  logic [CNT_W-1:0]  best;
  logic [CNT_W-1:0]  fin;
  logic              vb;
  logic              vc;

  logic [COIN_W-1:0] coin_q;
  logic [CNT_W-1:0]  tbl_q;
  logic [CNT_W-1:0]  unreach;
  logic [CNT_W-1:0]  cand;
  logic [CNT_W-1:0]  best_min;
  logic              coin_we;
  logic              coin_fits;
  logic              tgt_bad;
  logic              tbl_we;
  logic [TAW-1:0]    tbl_waddr;
  logic [CNT_W-1:0]  tbl_wdata;
  logic [TAW-1:0]    tbl_raddr;
  logic              fin_ok;

  assign unreach   = CNT_W'(target) + CNT_W'(1);
  assign tgt_bad   = (32'(target) >= 32'(MAX_AMOUNT));
  assign coin_we   = cmd.append && (req.coin_value != '0) &&
                     (coin_count < CCW'(MAX_COINS));

  // Stage B: coin read back, test against amount and address the table
  assign coin_fits = (COIN_W'(amt) >= coin_q);
  assign tbl_raddr = TAW'(amt - coin_q[AMT_W-1:0]);

  // Stage C: candidate from the finished entry
  assign cand      = tbl_q + CNT_W'(1);
  assign best_min  = (vc && (cand < best)) ? cand : best;

  // Table writes: entry zero at start, then one entry per amount
  assign tbl_we    = (cmd.init && !tgt_bad) || cmd.write;
  assign tbl_waddr = cmd.init ? '0 : TAW'(amt);
  assign tbl_wdata = cmd.init ? '0 : best_min;

  ccmd_ram #(.WIDTH(COIN_W), .DEPTH(MAX_COINS)) u_coin_ram (
    .clk   (clk),
    .we    (coin_we),
    .waddr (CIW'(coin_count)),
    .wdata (req.coin_value),
    .raddr (k),
    .rdata (coin_q)
  );

  ccmd_ram #(.WIDTH(CNT_W), .DEPTH(MAX_AMOUNT)) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_q)
  );

  // Control state: coin count, pipeline valids, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      coin_count <= '0;
      vb         <= 1'b0;
      vc         <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cmd.clear) begin
        coin_count <= '0;
      end else if (coin_we) begin
        coin_count <= coin_count + CCW'(1);
      end
      vb <= cmd.scan;
      vc <= vb && coin_fits;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      target <= req.target_amount;
    end
    if (cmd.init || cmd.write) begin
      best <= unreach;
    end else begin
      best <= best_min;
    end
    if (cmd.init) begin
      amt <= AMT_W'(1);
      k   <= '0;
      // zero target is trivially reachable; other early exits are not
      fin <= (tgt_bad || (target != '0)) ? unreach : '0;
    end else if (cmd.scan) begin
      k <= k + CIW'(1);
    end else if (cmd.write) begin
      k   <= '0;
      amt <= amt + AMT_W'(1);
      if (amt == target) begin
        fin <= best_min;
      end
    end
  end

  // Result register
  assign fin_ok = (fin < unreach);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp.reachable    <= fin_ok;
      rsp.fewest_coins <= fin_ok ? fin[AMT_W-1:0] : '0;
    end
  end

  assign sts.trivial   = tgt_bad || (target == '0) || (coin_count == '0);
  assign sts.last_coin = ((CCW'(k) + CCW'(1)) == coin_count);
  assign sts.last_amt  = (amt == target);
  assign sts.out_free  = !rsp_valid || rsp_ready;

endmodule

[src/ccmd_checker.sv]
// Port-level checks for the fewest-coins solver, bound to the top level.
module ccmd_checker (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_ready,
  input ccmd_pkg::req_t  req,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input ccmd_pkg::rsp_t  rsp
);
  import ccmd_pkg::*;

  // Result held while stalled
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed or dropped while stalled");

  // Unreachable answers carry a zero count
  a_unreach_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.reachable || (rsp.fewest_coins == '0)))
    else $error("unreachable result with nonzero count");

  // List updates finish at once
  a_list_fast: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req.opcode != OP_SOLVE) |=> req_ready)
    else $error("not ready after a list update");

  // A solve occupies the block
  a_solve_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req.opcode == OP_SOLVE) |=> !req_ready)
    else $error("ready straight after a solve");

  // No result straight out of reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind coin_change_min_coins_dp ccmd_checker u_ccmd_checker (.*);

[verif/tb.sv]
// Self-checking testbench for the fewest-coins solver: random stimulus, predictor and checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ccmd_pkg::*;

  localparam int COIN_SLOTS = 12;
  localparam int AMT_SPAN   = 16384;
  localparam logic [OPC_W-1:0] OP_SPARE = 2'd3;
  localparam int HOLD_CYCLES = 1500;
  localparam int RAND_ITEMS  = 70;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // Stimulus, expectations and coin-list mirror
  req_t pend_q[$];
  rsp_t want_q[$];
  int unsigned coin_list[COIN_SLOTS];
  int unsigned coin_n = 0;
  int unsigned fewest_tab[AMT_SPAN];

  int unsigned acc_cnt = 0;
  int unsigned dir_n = 0;
  int unsigned total_n = 0;
  int unsigned err_cnt = 0;
  bit stim_ready = 1'b0;

  // Handshake bookkeeping, sampled at the rising edge
  logic req_fire = 1'b0;
  logic rsp_fire = 1'b0;
  logic rsp_pend = 1'b0;
  logic rsp_hold = 1'b0;
  int unsigned req_wait = 0;
  int unsigned rsp_wait = 0;
  bit req_calm = 1'b0;
  bit rsp_calm = 1'b0;

  coin_change_min_coins_dp i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #10 clk = ~clk;

  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic add_item(input logic [OPC_W-1:0] opc, input int unsigned coin,
                          input int unsigned amt);
    req_t it;
    it.opcode        = opc;
    it.coin_value    = coin[COIN_W-1:0];
    it.target_amount = amt[AMT_W-1:0];
    pend_q.push_back(it);
  endtask

  // Mirror one accepted item: update the coin list, or tabulate a solve
  task automatic model_item(input req_t it);
    int unsigned tgt, unreach, amt, k, c, best, cand;
    rsp_t ans;
    case (it.opcode)
      OP_CLEAR: begin
        coin_n = 0;
      end
      OP_APPEND: begin
        if (it.coin_value != 0 && coin_n < COIN_SLOTS) begin
          coin_list[coin_n] = it.coin_value;
          coin_n++;
        end
      end
      OP_SOLVE: begin
        tgt = it.target_amount;
        unreach = tgt + 1;
        fewest_tab[0] = 0;
        for (amt = 1; amt <= tgt; amt++) begin
          best = unreach;
          for (k = 0; k < coin_n; k++) begin
            c = coin_list[k];
            if (c != 0 && c <= amt) begin
              cand = fewest_tab[amt - c] + 1;
              if (cand < best) best = cand;
            end
          end
          fewest_tab[amt] = best;
        end
        if (fewest_tab[tgt] >= unreach) begin
          ans.fewest_coins = '0;
          ans.reachable    = 1'b0;
        end else begin
          ans.fewest_coins = fewest_tab[tgt][AMT_W-1:0];
          ans.reachable    = 1'b1;
        end
        want_q.push_back(ans);
      end
      OP_SPARE: begin
        // spare opcode: nothing changes
      end
      default: begin
      end
    endcase
  endtask

  // Request driver: holds the item until taken, then may idle for a random gap
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_fire) begin
      if (req_wait != 0) begin
        req_wait  <= req_wait - 1;
        req_valid <= 1'b0;
      end else if (pend_q.size() != 0) begin
        req       <= pend_q.pop_front();
        req_valid <= 1'b1;
        if ($urandom_range(0, 15) == 0) req_calm <= !req_calm;
        req_wait  <= req_calm ? 0 : $urandom_range(0, 3);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Result receiver: inserts random stalls after each result, plus the long hold-off
  always @(negedge clk) begin : rsp_drive
    int unsigned nw;
    if (rst) begin
      rsp_ready <= 1'b0;
      rsp_wait  <= 0;
    end else if (rsp_fire) begin
      if ($urandom_range(0, 7) == 0) rsp_calm <= !rsp_calm;
      nw = rsp_calm ? 0 : $urandom_range(0, 3);
      rsp_wait  <= nw;
      rsp_ready <= !rsp_hold && nw == 0;
    end else if (rsp_wait != 0) begin
      if (rsp_pend) rsp_wait <= rsp_wait - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= !rsp_hold;
    end
  end

  // Long hold-off once the directed part has drained, so the solver backs up
  initial begin : hold_off
    wait (stim_ready && acc_cnt >= dir_n);
    wait (want_q.size() == 0);
    @(posedge clk);
    rsp_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rsp_hold <= 1'b0;
  end

  // Monitor: check results against the oldest expectation, mirror accepted items
  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      req_fire <= 1'b0;
      rsp_fire <= 1'b0;
      rsp_pend <= 1'b0;
    end else begin
      req_fire <= req_valid && req_ready;
      rsp_fire <= rsp_valid && rsp_ready;
      rsp_pend <= rsp_valid && !rsp_ready;
      if (rsp_valid && rsp_ready) begin
        if (want_q.size() == 0) begin
          flag_error($sformatf("result with none pending: fewest_coins %0d reachable %0b",
                               rsp.fewest_coins, rsp.reachable));
        end else begin
          want = want_q.pop_front();
          if (rsp.fewest_coins !== want.fewest_coins)
            flag_error($sformatf("fewest_coins: expected %0d, got %0d",
                                 want.fewest_coins, rsp.fewest_coins));
          if (rsp.reachable !== want.reachable)
            flag_error($sformatf("reachable: expected %0b, got %0b",
                                 want.reachable, rsp.reachable));
        end
      end
      if (req_valid && req_ready) begin
        acc_cnt <= acc_cnt + 1;
        model_item(req);
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin : stimulus
    int unsigned n_rand, gen_n, pick, coin;
    int unsigned primes[10];
    primes = '{7, 11, 13, 17, 19, 23, 29, 31, 37, 2};

    // Directed: empty list, ignored items, oversize coin, full list, widest target
    add_item(OP_SOLVE, 16'h5a5a, 0);
    add_item(OP_SOLVE, 0, 5);
    add_item(OP_APPEND, 0, 14'h3fff);
    add_item(OP_SPARE, 16'hffff, 14'h3fff);
    add_item(OP_APPEND, 16'hffff, 0);
    add_item(OP_SOLVE, 0, 7);
    add_item(OP_CLEAR, 16'hffff, 14'h3fff);
    add_item(OP_APPEND, 3, 0);
    add_item(OP_APPEND, 5, 0);
    add_item(OP_SOLVE, 0, 7);
    add_item(OP_SOLVE, 0, 11);
    for (int i = 0; i < 10; i++) add_item(OP_APPEND, primes[i], 0);
    // list is full: this coin is dropped, so 1 stays unreachable
    add_item(OP_APPEND, 1, 0);
    add_item(OP_SOLVE, 0, 1);
    add_item(OP_SOLVE, 0, 100);
    add_item(OP_CLEAR, 0, 0);
    add_item(OP_APPEND, 1, 0);
    add_item(OP_SOLVE, 0, 14'h3fff);
    dir_n = pend_q.size();

    // Random: opens with a burst of small solves for the hold-off
    add_item(OP_CLEAR, $urandom_range(0, 65535), $urandom_range(0, 16383));
    add_item(OP_APPEND, $urandom_range(1, 10), $urandom_range(0, 16383));
    for (int i = 0; i < 4; i++)
      add_item(OP_SOLVE, $urandom_range(0, 65535), $urandom_range(0, 30));
    n_rand = 6;
    gen_n = 1;
    while (n_rand < RAND_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick <= 1) begin
        add_item(OP_CLEAR, $urandom_range(0, 65535), $urandom_range(0, 16383));
        gen_n = 0;
        n_rand++;
      end else if (pick <= 8) begin
        case ($urandom_range(0, 9))
          0:       coin = 0;
          1:       coin = $urandom_range(0, 65535);
          default: coin = $urandom_range(1, 40);
        endcase
        add_item(OP_APPEND, coin, $urandom_range(0, 16383));
        if (coin != 0 && gen_n < COIN_SLOTS) begin
          gen_n++;
          n_rand++;
        end
      end else if (pick <= 18) begin
        add_item(OP_SOLVE, $urandom_range(0, 65535),
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1000) : $urandom_range(0, 150));
        n_rand++;
      end else begin
        add_item(OP_SPARE, $urandom_range(0, 65535), $urandom_range(0, 16383));
      end
    end
    total_n = pend_q.size();
    stim_ready = 1'b1;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (acc_cnt < total_n) @(posedge clk);
    while (want_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #80ms;
    $display("timeout: %0d items accepted, %0d results pending", acc_cnt, want_q.size());
    $display("tb NOT OK");
    $finish;
  end

endmodule
